// ===== design/kvc_pkg.sv =====
// ----------------------------------------------------------------------------
// kvc_pkg
// Shared constants and types of the keyboard voice channel allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvc_pkg;

  parameter int unsigned CHANNELS   = 64;
  parameter int unsigned NOTE_COUNT = 120;
  parameter int unsigned IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  parameter int unsigned CHAN_W  = 6;
  parameter int unsigned NOTE_W  = 7;
  parameter int unsigned VOL_W   = 8;
  parameter int unsigned INSTR_W = 8;
  parameter int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_STOP    = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PRESS = 5'b00010,
    S_REL   = 5'b00100,
    S_STOP  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  // one event from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  channel;
    logic              is_off;
    logic [NOTE_W-1:0] note;
    logic [VOL_W-1:0]  volume;
    logic              last;
  } evt_t;

endpackage

`default_nettype wire

// ===== design/kvc_ram.sv =====
// ----------------------------------------------------------------------------
// kvc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/kvc_seq.sv =====
// ----------------------------------------------------------------------------
// kvc_seq
// Channel scan sequencer: occupancy bits, note store and one shared
// index/compare unit walking the channels from the top down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvc_seq
  import kvc_pkg::IDX_W, kvc_pkg::NOTE_W, kvc_pkg::VOL_W, kvc_pkg::OP_W,
         kvc_pkg::evt_t;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [NOTE_W-1:0] note_i,
  input  wire logic [VOL_W-1:0]  volume_i,
  output logic                   busy_o,
  output evt_t                   evt_o
);
  import kvc_pkg::*;

  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [IDX_W-1:0] ZERO_IDX = '0;

  state_e              state_q, state_d;
  logic [CHANNELS-1:0] used_q, used_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    pend_idx_q, pend_idx_d;
  logic [NOTE_W-1:0]   note_q, note_d;
  logic [VOL_W-1:0]    vol_q, vol_d;

  logic                ram_we;
  logic [NOTE_W-1:0]   ram_rdata;
  logic                note_ok;
  evt_t                evt;

  kvc_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (CHANNELS)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (note_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign note_ok = ({1'b0, note_i} < 8'(NOTE_COUNT));

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    idx_d      = idx_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = cmp_vld_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    note_d     = note_q;
    vol_d      = vol_q;
    ram_we     = 1'b0;
    evt        = '0;

    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          note_d    = note_i;
          vol_d     = volume_i;
          idx_d     = TOP_IDX;
          cmp_vld_d = 1'b0;
          pend_d    = 1'b0;
          case (op_e'(opcode_i))
            OP_PRESS:   if (note_ok) state_d = S_PRESS;
            OP_RELEASE: if (note_ok) state_d = S_REL;
            OP_STOP:    state_d = S_STOP;
            default:    state_d = S_IDLE;
          endcase
        end
      end

      S_PRESS: begin
        // channel 0 is taken over when every channel is busy
        if (!used_q[idx_q] || idx_q == ZERO_IDX) begin
          used_d[idx_q] = 1'b1;
          ram_we        = 1'b1;
          evt.valid     = 1'b1;
          evt.channel   = idx_q;
          evt.note      = note_q;
          evt.volume    = vol_q;
          evt.last      = 1'b1;
          state_d       = S_IDLE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end

      S_REL: begin
        // read data for the issued index arrives in the cycle after it
        if (cmp_vld_q && used_q[cmp_idx_q] && ram_rdata == note_q) begin
          used_d[cmp_idx_q] = 1'b0;
          evt.valid         = 1'b1;
          evt.channel       = cmp_idx_q;
          evt.is_off        = 1'b1;
          evt.last          = 1'b1;
          state_d           = S_IDLE;
        end else if (cmp_vld_q && cmp_idx_q == ZERO_IDX) begin
          state_d = S_IDLE;
        end else begin
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
          if (idx_q != ZERO_IDX) begin
            idx_d = idx_q - 1'b1;
          end
        end
      end

      S_STOP: begin
        // hold one found channel back so the final one can carry last
        if (used_q[idx_q]) begin
          used_d[idx_q] = 1'b0;
          pend_d        = 1'b1;
          pend_idx_d    = idx_q;
          if (pend_q) begin
            evt.valid   = 1'b1;
            evt.channel = pend_idx_q;
            evt.is_off  = 1'b1;
          end
        end
        if (idx_q == ZERO_IDX) begin
          state_d = S_FLUSH;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end

      S_FLUSH: begin
        if (pend_q) begin
          evt.valid   = 1'b1;
          evt.channel = pend_idx_q;
          evt.is_off  = 1'b1;
          evt.last    = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      cmp_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      cmp_vld_q <= cmp_vld_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    pend_idx_q <= pend_idx_d;
    note_q     <= note_d;
    vol_q      <= vol_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign evt_o  = evt;

endmodule

`default_nettype wire

// ===== design/keyboard_voice_channel_allocator.sv =====
// ----------------------------------------------------------------------------
// keyboard_voice_channel_allocator
// Polyphonic channel allocator for key press, key release and stop-all.
// ----------------------------------------------------------------------------
// scan: press stops at the first free channel from the top (else channel 0),
//   release at the matching channel; stop-all and an unmatched release after channel 0
// throughput: one command per scan, taken only while not busy; the serial
//   channel scan (one channel per cycle) sets it
// reset: asynchronous, all channels empty, instrument 0, no strobe
// results are strobed for one cycle each; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module keyboard_voice_channel_allocator
  import kvc_pkg::OP_W, kvc_pkg::NOTE_W, kvc_pkg::VOL_W, kvc_pkg::INSTR_W,
         kvc_pkg::CHAN_W;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [OP_W-1:0]    opcode_i,
  input  wire logic [NOTE_W-1:0]  note_i,
  input  wire logic [VOL_W-1:0]   volume_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [INSTR_W-1:0] cfg_data_i,
  output logic                    valid_o,
  output logic [CHAN_W-1:0]       channel_o,
  output logic                    is_off_o,
  output logic [NOTE_W-1:0]       note_out_o,
  output logic [VOL_W-1:0]        volume_out_o,
  output logic [INSTR_W-1:0]      instrument_out_o,
  output logic                    last_o
);
  import kvc_pkg::*;

  logic               seq_busy;
  evt_t               evt;
  logic [INSTR_W-1:0] instrument_q;
  logic               valid_q;
  logic [CHAN_W-1:0]  channel_q;
  logic               is_off_q;
  logic [NOTE_W-1:0]  note_q;
  logic [VOL_W-1:0]   vol_q;
  logic [INSTR_W-1:0] instr_q;
  logic               last_q;

  kvc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !seq_busy),
    .opcode_i (opcode_i),
    .note_i   (note_i),
    .volume_i (volume_i),
    .busy_o   (seq_busy),
    .evt_o    (evt)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instrument_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        instrument_q <= cfg_data_i;
      end
      valid_q <= evt.valid;
    end
  end

  // note-off carries zero note, volume and instrument
  always_ff @(posedge clk_i) begin
    if (evt.valid) begin
      channel_q <= CHAN_W'(evt.channel);
      is_off_q  <= evt.is_off;
      note_q    <= evt.note;
      vol_q     <= evt.volume;
      instr_q   <= evt.is_off ? '0 : instrument_q;
      last_q    <= evt.last;
    end
  end

  assign busy             = seq_busy;
  assign valid_o          = valid_q;
  assign channel_o        = channel_q;
  assign is_off_o         = is_off_q;
  assign note_out_o       = note_q;
  assign volume_out_o     = vol_q;
  assign instrument_out_o = instr_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

// ===== design/kvc_checker.sv =====
// ----------------------------------------------------------------------------
// kvc_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvc_checker
  import kvc_pkg::NOTE_W, kvc_pkg::VOL_W, kvc_pkg::INSTR_W;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               valid_o,
  input wire logic               is_off_o,
  input wire logic [NOTE_W-1:0]  note_out_o,
  input wire logic [VOL_W-1:0]   volume_out_o,
  input wire logic [INSTR_W-1:0] instrument_out_o,
  input wire logic               last_o
);

  // more results of the same command still to come
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("non-final result while block idle");

  // no result transfer right after a command is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !valid_o)
    else $error("result too soon after command");

  a_note_on_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !is_off_o |-> last_o)
    else $error("note-on not marked last");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_off_o |->
      note_out_o == '0 && volume_out_o == '0 && instrument_out_o == '0)
    else $error("note-off with nonzero payload");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without a command");

endmodule

bind keyboard_voice_channel_allocator kvc_checker u_kvc_checker (.*);

`default_nettype wire
